FILE: hw/rtl/bsuf_pkg.sv
package bsuf_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int CFG_AW = 2;
    localparam int CFG_DW = 11;

    localparam logic [CFG_AW-1:0] REG_THRESH = 2'd0;
    localparam logic [CFG_AW-1:0] REG_MARGIN = 2'd1;
    localparam logic [CFG_AW-1:0] REG_WIDTH  = 2'd2;
    localparam logic [CFG_AW-1:0] REG_HEIGHT = 2'd3;

    localparam logic [1:0] MODE_UPDATE = 2'd0;
    localparam logic [1:0] MODE_READ   = 2'd1;
    localparam logic [1:0] MODE_FILL   = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic        in_frame;
        logic        upd;
        logic        last;
        logic [9:0]  row;
        logic [9:0]  col;
        logic [7:0]  depth;
        logic [23:0] colour;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD, ST_RESP, ST_E_RD0, ST_E_RD1, ST_E_WAIT, ST_E_CMP,
        ST_E_NEXT, ST_CLR
    } bk_state_t;

endpackage

FILE: hw/rtl/bsuf_front.sv
module bsuf_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           mode,
    input  logic [9:0]           pixel_row,
    input  logic [9:0]           pixel_col,
    input  logic [7:0]           depth_in,
    input  logic [7:0]           blue_in,
    input  logic [7:0]           green_in,
    input  logic [7:0]           red_in,
    input  logic                 last_pixel,
    input  logic [7:0]           thresh,
    input  logic [10:0]          used_w,
    input  logic [10:0]          used_h,
    output logic                 q_valid,
    output bsuf_pkg::cmd_t       q_cmd,
    input  logic                 q_pop
);
    // two-entry queue
    bsuf_pkg::cmd_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    bsuf_pkg::cmd_t c;
    logic push;

    always_comb
    begin
        c.mode     = mode;
        c.in_frame = ({1'b0, pixel_row} < used_h) && ({1'b0, pixel_col} < used_w);
        c.upd      = (mode == bsuf_pkg::MODE_UPDATE) && c.in_frame && (depth_in < thresh);
        c.last     = last_pixel && (mode == bsuf_pkg::MODE_UPDATE);
        c.row      = pixel_row;
        c.col      = pixel_col;
        c.depth    = depth_in;
        c.colour   = {red_in, green_in, blue_in};
    end

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (q_pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid) else $error("pop from empty queue");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue count overflow");
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) |-> in_stall) else $error("full queue not stalling");
`endif
endmodule

FILE: hw/rtl/bsuf_back.sv
module bsuf_back #(
    parameter int MAX_WIDTH  = bsuf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bsuf_pkg::MAX_HEIGHT_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  bsuf_pkg::cmd_t       q_cmd,
    output logic                 q_pop,
    input  logic [7:0]           margin,
    input  logic [10:0]          used_w,
    input  logic [10:0]          used_h,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           blue_out,
    output logic [7:0]           green_out,
    output logic [7:0]           red_out,
    output logic [7:0]           depth_out,
    output logic                 frame_done
);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int AW = CW + RW;
    localparam int DEPTH = 1 << AW;
    localparam int IW = (CW > RW ? CW : RW) + 1;

    logic [31:0] mem [DEPTH];
    logic [31:0] rd_data;
    logic [AW-1:0] rd_addr;
    logic          we;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;

    bsuf_pkg::bk_state_t st_reg, st_next;
    bsuf_pkg::cmd_t cmd_reg, cmd_next;
    logic [AW:0]   clr_reg, clr_next;
    logic          pass_reg, pass_next;   // 0 rows, 1 columns
    logic [IW-1:0] o_reg, o_next;         // outer index
    logic [IW-1:0] i_reg, i_next;         // inner index
    logic [7:0]    a_reg, a_next;
    logic [7:0]  ob_reg, og_reg, or_reg, od_reg;
    logic [7:0]  ob_next, og_next, or_next, od_next;
    logic        fd_reg, fd_next, ov_reg, ov_next;
    logic [AW-1:0] ea, eb;
    logic [IW-1:0] o_lim, i_lim;
    logic [8:0]  sum;
    logic [AW-1:0] pa;

    assign pa = {RW'(q_cmd.row), CW'(q_cmd.col)};
    assign ea = pass_reg ? {i_reg[RW-1:0], o_reg[CW-1:0]} : {o_reg[RW-1:0], i_reg[CW-1:0]};
    assign eb = pass_reg ? {i_reg[RW-1:0] + RW'(1), o_reg[CW-1:0]}
                         : {o_reg[RW-1:0], i_reg[CW-1:0] + CW'(1)};
    assign o_lim = pass_reg ? IW'(used_w) : IW'(used_h);
    assign i_lim = pass_reg ? IW'(used_h) : IW'(used_w);
    assign sum = {1'b0, rd_data[31:24]} + {1'b0, margin};

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= bsuf_pkg::ST_CLR;
            clr_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            clr_reg <= clr_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next; pass_reg <= pass_next; o_reg <= o_next; i_reg <= i_next;
        a_reg <= a_next; ob_reg <= ob_next; og_reg <= og_next; or_reg <= or_next;
        od_reg <= od_next; fd_reg <= fd_next;
    end

    always_comb
    begin
        st_next = st_reg; cmd_next = cmd_reg; clr_next = clr_reg;
        pass_next = pass_reg; o_next = o_reg; i_next = i_reg; a_next = a_reg;
        ob_next = ob_reg; og_next = og_reg; or_next = or_reg; od_next = od_reg;
        fd_next = fd_reg; ov_next = ov_reg;
        q_pop = 1'b0; we = 1'b0; wr_addr = ea; wr_data = '0; rd_addr = ea;
        if (ov_reg && !out_stall)
            ov_next = 1'b0;
        unique case (st_reg)
            bsuf_pkg::ST_CLR:
            begin
                we = 1'b1; wr_addr = clr_reg[AW-1:0];
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (AW+1)'(DEPTH - 1))
                    st_next = bsuf_pkg::ST_IDLE;
            end
            bsuf_pkg::ST_IDLE:
                // the output register frees at this edge if its result is taken
                if (q_valid && (!ov_reg || !out_stall))
                begin
                    q_pop = 1'b1; cmd_next = q_cmd;
                    we = q_cmd.upd; wr_addr = pa;
                    wr_data = {q_cmd.depth, q_cmd.colour};
                    pass_next = 1'b0; o_next = '0; i_next = '0;
                    st_next = q_cmd.last ? bsuf_pkg::ST_E_NEXT : bsuf_pkg::ST_RD;
                end
            bsuf_pkg::ST_RD:
            begin
                rd_addr = {RW'(cmd_reg.row), CW'(cmd_reg.col)};
                st_next = bsuf_pkg::ST_RESP;
            end
            bsuf_pkg::ST_RESP:
            begin
                ob_next = 8'd0; og_next = 8'd0; or_next = 8'd0; od_next = 8'd0;
                fd_next = cmd_reg.last;
                if (cmd_reg.in_frame && cmd_reg.mode != bsuf_pkg::MODE_UNUSED)
                    od_next = rd_data[31:24];
                if (cmd_reg.mode == bsuf_pkg::MODE_READ && cmd_reg.in_frame)
                    {or_next, og_next, ob_next} = rd_data[23:0];
                else if (cmd_reg.mode == bsuf_pkg::MODE_FILL)
                begin
                    {or_next, og_next, ob_next} = cmd_reg.colour;
                    if (cmd_reg.colour == 24'd0 && cmd_reg.in_frame && rd_data[31:24] != 8'd0)
                    begin
                        if ({1'b0, cmd_reg.depth} < sum)
                            {or_next, og_next, ob_next} = rd_data[23:0];
                        else
                            {or_next, og_next, ob_next} = 24'd0;
                    end
                end
                ov_next = 1'b1;
                st_next = bsuf_pkg::ST_IDLE;
            end
            bsuf_pkg::ST_E_NEXT:
            begin
                // step to next pair; finish pass when outer exhausted
                if (o_reg >= o_lim)
                begin
                    if (pass_reg) st_next = bsuf_pkg::ST_RD;
                    else begin pass_next = 1'b1; o_next = '0; i_next = '0; end
                end
                else if ({1'b0, i_reg} + 1'b1 >= {1'b0, i_lim})
                begin
                    o_next = o_reg + 1'b1; i_next = '0;
                end
                else
                    st_next = bsuf_pkg::ST_E_RD0;
            end
            bsuf_pkg::ST_E_RD0:
            begin
                rd_addr = ea; st_next = bsuf_pkg::ST_E_RD1;
            end
            bsuf_pkg::ST_E_RD1:
            begin
                rd_addr = eb; a_next = rd_data[31:24]; st_next = bsuf_pkg::ST_E_CMP;
            end
            bsuf_pkg::ST_E_CMP:
            begin
                if ((a_reg == 8'd0) != (rd_data[31:24] == 8'd0))
                begin
                    we = 1'b1; wr_addr = ea;
                    i_next = i_reg + IW'(2);
                    st_next = bsuf_pkg::ST_E_WAIT;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                    st_next = bsuf_pkg::ST_E_NEXT;
                end
            end
            bsuf_pkg::ST_E_WAIT:
            begin
                // clear second of the pair; address rebuilt from the advanced index
                we = 1'b1;
                wr_addr = pass_reg ? {i_reg[RW-1:0] - RW'(1), o_reg[CW-1:0]}
                                   : {o_reg[RW-1:0], i_reg[CW-1:0] - CW'(1)};
                st_next = bsuf_pkg::ST_E_NEXT;
            end
            default: st_next = bsuf_pkg::ST_IDLE;
        endcase
    end

    assign out_valid = ov_reg;
    assign blue_out = ob_reg; assign green_out = og_reg; assign red_out = or_reg;
    assign depth_out = od_reg; assign frame_done = fd_reg;

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && out_stall) |=> ov_reg) else $error("result dropped");
    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (st_reg == bsuf_pkg::ST_IDLE)) else $error("pop while busy");
    a_resp_free: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == bsuf_pkg::ST_RESP) |-> !ov_reg) else $error("result overwritten");
`endif
endmodule

FILE: hw/rtl/background_sprite_update_fill_core.sv
// An accepted input transaction is handled as pop with store write, then read, then
// respond; the next item is popped only after that, once the output register is free.
// A frame-end item adds an edge erase: each neighbour pair is read and compared and is
// cleared when exactly one entry is zero, over the row pass then the column pass.
// Reset (rst_n, asynchronous, low) clears control state, then sweeps the sprite memory
// one entry per cycle (MAX_WIDTH*MAX_HEIGHT at the default size) before serving items.
module background_sprite_update_fill_core #(
    parameter int MAX_WIDTH  = bsuf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bsuf_pkg::MAX_HEIGHT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [9:0]  pixel_row,
    input  logic [9:0]  pixel_col,
    input  logic [7:0]  depth_in,
    input  logic [7:0]  blue_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  red_in,
    input  logic        last_pixel,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  blue_out,
    output logic [7:0]  green_out,
    output logic [7:0]  red_out,
    output logic [7:0]  depth_out,
    output logic        frame_done
);
    logic [7:0]  thresh_reg, margin_reg;
    logic [10:0] width_reg, height_reg, used_w, used_h;
    logic        q_valid, q_pop;
    bsuf_pkg::cmd_t q_cmd;

    // hold configuration; saturate frame size to the store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= 8'd0;
            margin_reg <= 8'd15;
            width_reg  <= 11'd1024;
            height_reg <= 11'd1024;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bsuf_pkg::REG_THRESH: thresh_reg <= cfg_data[7:0];
                bsuf_pkg::REG_MARGIN: margin_reg <= cfg_data[7:0];
                bsuf_pkg::REG_WIDTH:  width_reg  <= cfg_data;
                bsuf_pkg::REG_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign used_w = (32'(width_reg) > MAX_WIDTH) ? 11'(MAX_WIDTH) : width_reg;
    assign used_h = (32'(height_reg) > MAX_HEIGHT) ? 11'(MAX_HEIGHT) : height_reg;

    // front classifies the transaction, back carries it out on the store
    bsuf_front u_front (
        .clk, .rst_n, .in_valid, .in_stall, .mode, .pixel_row, .pixel_col,
        .depth_in, .blue_in, .green_in, .red_in, .last_pixel,
        .thresh(thresh_reg), .used_w, .used_h, .q_valid, .q_cmd, .q_pop);

    bsuf_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
        .clk, .rst_n, .q_valid, .q_cmd, .q_pop, .margin(margin_reg), .used_w, .used_h,
        .out_valid, .out_stall, .blue_out, .green_out, .red_out, .depth_out,
        .frame_done);
endmodule
